### rtl/core/dtc_pkg.sv
`default_nettype none

package dtc_pkg;

    // calibration register indexes
    localparam logic [7:0] REG_BAND_GAP  = 8'd0;
    localparam logic [7:0] REG_DEV_REF   = 8'd1;
    localparam logic [7:0] REG_DEV_AUX_A = 8'd2;
    localparam logic [7:0] REG_DEV_AUX_B = 8'd3;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_REJECTED = 2'd1;
    localparam logic [1:0] STATUS_BAD_GAP  = 2'd2;

    // band-gap limits and fallback
    localparam logic [15:0] VBG_MIN     = 16'd2300;
    localparam logic [15:0] VBG_MAX     = 16'd3000;
    localparam logic [15:0] VBG_DEFAULT = 16'd2700;

    // allowed reference gap
    localparam logic [7:0] GAP_MIN = 8'd43;
    localparam logic [7:0] GAP_MAX = 8'd51;

    localparam logic [3:0] ID_BIAS   = 4'd9;
    localparam logic [9:0] TEMP_BIAS = 10'd240;
    localparam int RESULT_SHIFT      = 23;

    typedef logic [7:0] t_level;

    // middle value of three bytes
    function automatic t_level median3(input t_level a, input t_level b, input t_level c);
        t_level m;
        if (a > b) begin
            if (a > c) m = (b > c) ? b : c;
            else       m = a;
        end else begin
            if (b > c) m = (a > c) ? a : c;
            else       m = b;
        end
        return m;
    endfunction

    // reciprocal table, round(2^23 / (gap * 90)) for gap 43..51
    function automatic logic [11:0] recip_lut(input t_level gap);
        logic [11:0] r;
        unique case (gap)
            8'd43:   r = 12'd2168;
            8'd44:   r = 12'd2118;
            8'd45:   r = 12'd2071;
            8'd46:   r = 12'd2026;
            8'd47:   r = 12'd1983;
            8'd48:   r = 12'd1942;
            8'd49:   r = 12'd1902;
            8'd50:   r = 12'd1864;
            8'd51:   r = 12'd1828;
            default: r = 12'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/dtc_in_if.sv
`default_nettype none

interface dtc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] diode_sample;
    logic       pass_seen;
    logic [7:0] ref_level_0;
    logic [7:0] ref_level_1;
    logic [7:0] ref_level_2;
    logic [7:0] ref_level_3;
    logic [7:0] ref_level_4;

    modport source (
        output valid, diode_sample, pass_seen,
               ref_level_0, ref_level_1, ref_level_2, ref_level_3, ref_level_4,
        input  ready
    );
    modport sink (
        input  valid, diode_sample, pass_seen,
               ref_level_0, ref_level_1, ref_level_2, ref_level_3, ref_level_4,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/dtc_out_if.sv
`default_nettype none

interface dtc_out_if;
    logic              valid;
    logic              ready;
    logic signed [9:0] temperature;
    logic        [1:0] status;

    modport source (output valid, temperature, status, input ready);
    modport sink (input valid, temperature, status, output ready);
endinterface

`default_nettype wire

### rtl/core/dtc_cfg_if.sv
`default_nettype none

interface dtc_cfg_if
    import dtc_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/diode_temperature_conversion.sv
// Diode temperature conversion
//
// i_in is the sample channel: one averaged diode sample, its pass-once bit
// and five reference levels per transaction. o_out returns exactly one
// transaction per sample, in order: temperature in degrees and a status
// (ok, sample rejected, reference gap out of range; temperature is 0
// unless ok). i_cfg writes the band-gap word and the three deviation
// bytes; it is always ready and should only be used while no sample is in
// flight.
// The datapath is a four-stage pipeline: sample correction, reference
// selection, reciprocal multiply, band-gap multiply with final scaling.
// Each sample passes through the stage registers r1 to r4 in turn, and r4
// drives o_out; one sample can be accepted every cycle while o_out is not
// stalled. The two multiplies each own a stage and set the stage depth.
// When the receiver stalls o_out the whole pipeline holds and i_in.ready
// drops, so nothing is lost or repeated. Synchronous reset empties the
// pipeline and restores the calibration registers (band gap 2700,
// deviation bytes 0).
`default_nettype none

module diode_temperature_conversion
    import dtc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    dtc_in_if.sink     i_in,
    dtc_cfg_if.sink    i_cfg,
    dtc_out_if.source  o_out
);

    // calibration registers
    logic [15:0] r_band_gap;
    logic [7:0]  r_dev_ref;
    logic [7:0]  r_dev_aux_a;
    logic [7:0]  r_dev_aux_b;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_gap  <= VBG_DEFAULT;
            r_dev_ref   <= '0;
            r_dev_aux_a <= '0;
            r_dev_aux_b <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_BAND_GAP:  r_band_gap  <= i_cfg.data;
                REG_DEV_REF:   r_dev_ref   <= i_cfg.data[7:0];
                REG_DEV_AUX_A: r_dev_aux_a <= i_cfg.data[7:0];
                REG_DEV_AUX_B: r_dev_aux_b <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // pipeline advance: everything moves unless the output is stalled
    logic w_adv;
    logic r4_valid;
    assign w_adv      = !r4_valid || o_out.ready;
    assign i_in.ready = w_adv;

    // stage 1: deviation correction and clamp
    logic [7:0]        w_median;
    logic signed [8:0] w_offset;
    logic signed [9:0] w_corr;
    logic [7:0]        n1_sample;

    always_comb begin
        w_median = median3(r_dev_ref, r_dev_aux_a, r_dev_aux_b);
        w_offset = $signed({1'b0, r_dev_ref}) - $signed({1'b0, w_median});
        w_corr   = $signed({2'b00, i_in.diode_sample}) - 10'(w_offset);
        if (w_corr > 10'sd255)     n1_sample = 8'd255;
        else if (w_corr < 10'sd0)  n1_sample = 8'd0;
        else                       n1_sample = w_corr[7:0];
    end

    logic       r1_valid;
    logic [7:0] r1_sample;
    logic       r1_pass;
    logic [7:0] r1_ref [5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_valid <= 1'b0;
        else if (w_adv) r1_valid <= i_in.valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_sample <= n1_sample;
            r1_pass   <= i_in.pass_seen;
            r1_ref[0] <= i_in.ref_level_0;
            r1_ref[1] <= i_in.ref_level_1;
            r1_ref[2] <= i_in.ref_level_2;
            r1_ref[3] <= i_in.ref_level_3;
            r1_ref[4] <= i_in.ref_level_4;
        end
    end

    // stage 2: reference pair selection, gap check, linear term
    logic [1:0]         w_idx;
    logic [7:0]         w_lo;
    logic [7:0]         w_hi;
    logic [7:0]         w_diff;
    logic [11:0]        w_scaled;
    logic [1:0]         n2_status;
    logic signed [12:0] n2_lin;

    always_comb begin
        priority if (r1_sample > r1_ref[3]) w_idx = 2'd3;
        else if (r1_sample > r1_ref[2])     w_idx = 2'd2;
        else if (r1_sample > r1_ref[1])     w_idx = 2'd1;
        else                                w_idx = 2'd0;
        w_lo     = r1_ref[{1'b0, w_idx}];
        w_hi     = r1_ref[3'({1'b0, w_idx}) + 3'd1];
        w_diff   = w_hi - w_lo;
        w_scaled = w_diff * ({2'b00, w_idx} + ID_BIAS);
        n2_lin   = $signed({1'b0, w_scaled}) + $signed({5'd0, r1_sample})
                 - $signed({5'd0, w_hi});
        priority if (r1_sample < r1_ref[0] || r1_sample > r1_ref[4] || !r1_pass)
            n2_status = STATUS_REJECTED;
        else if (w_diff < GAP_MIN || w_diff > GAP_MAX)
            n2_status = STATUS_BAD_GAP;
        else
            n2_status = STATUS_OK;
    end

    logic               r2_valid;
    logic [1:0]         r2_status;
    logic signed [12:0] r2_lin;
    logic [11:0]        r2_recip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_valid <= 1'b0;
        else if (w_adv) r2_valid <= r1_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_status <= n2_status;
            r2_lin    <= n2_lin;
            r2_recip  <= recip_lut(w_diff);
        end
    end

    // stage 3: reciprocal multiply, band-gap selection
    logic signed [25:0] w_prod1;
    logic [11:0]        n3_vbg;

    always_comb begin
        w_prod1 = r2_lin * $signed({1'b0, r2_recip});
        if (r_band_gap < VBG_MIN || r_band_gap > VBG_MAX) n3_vbg = VBG_DEFAULT[11:0];
        else                                              n3_vbg = r_band_gap[11:0];
    end

    logic        r3_valid;
    logic [1:0]  r3_status;
    logic [31:0] r3_prod;
    logic [11:0] r3_vbg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_valid <= 1'b0;
        else if (w_adv) r3_valid <= r2_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_status <= r2_status;
            r3_prod   <= 32'(w_prod1);
            r3_vbg    <= n3_vbg;
        end
    end

    // stage 4: band-gap multiply, scale and bias
    logic [43:0] w_prod2;
    logic [9:0]  n4_temp;

    always_comb begin
        w_prod2 = r3_prod * r3_vbg;
        if (r3_status == STATUS_OK)
            n4_temp = {1'b0, w_prod2[31:RESULT_SHIFT]} - TEMP_BIAS;
        else
            n4_temp = '0;
    end

    logic        r4_status_ok;
    logic [1:0]  r4_status;
    logic [9:0]  r4_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_valid <= 1'b0;
        else if (w_adv) r4_valid <= r3_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_status    <= r3_status;
            r4_status_ok <= (r3_status == STATUS_OK);
            r4_temp      <= n4_temp;
        end
    end

    assign o_out.valid       = r4_valid;
    assign o_out.status      = r4_status;
    assign o_out.temperature = r4_status_ok ? $signed(r4_temp) : 10'sd0;

endmodule

`default_nettype wire

### rtl/core/dtc_checker.sv
`default_nettype none

module dtc_checker
    import dtc_pkg::*;
(
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_in_ready,
    input wire              i_out_valid,
    input wire              i_out_ready,
    input wire signed [9:0] i_out_temperature,
    input wire        [1:0] i_out_status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_temperature)
            && $stable(i_out_status))
        else $error("stalled result changed");

    // pipeline only backpressures while the output is stalled
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_out_valid && !i_out_ready) |-> i_in_ready)
        else $error("input not ready without output stall");

    // failed results carry a zero temperature, status never undefined code
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != STATUS_OK |->
            i_out_temperature == 10'sd0 &&
            (i_out_status == STATUS_REJECTED || i_out_status == STATUS_BAD_GAP))
        else $error("bad status or nonzero temperature on failure");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind diode_temperature_conversion dtc_checker u_dtc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_temperature (o_out.temperature),
    .i_out_status      (o_out.status)
);

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps

// one sample transaction as the testbench builds and observes it
typedef struct packed {
    logic [7:0]      sample;
    logic            pass;
    logic [4:0][7:0] lvl;
} t_sample;

// one result transaction
typedef struct packed {
    logic [9:0] temp;
    logic [1:0] status;
} t_reading;

// calibration copy, temperature prediction and in-order result check
class temp_scoreboard;
    logic [15:0] band_gap;
    logic [7:0]  dev_ref;
    logic [7:0]  dev_a;
    logic [7:0]  dev_b;
    t_reading    reading_q[$];
    int          errors;

    function new();
        band_gap = dtc_pkg::VBG_DEFAULT;
        dev_ref  = '0;
        dev_a    = '0;
        dev_b    = '0;
        errors   = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [15:0] val);
        case (idx)
            dtc_pkg::REG_BAND_GAP:  band_gap = val;
            dtc_pkg::REG_DEV_REF:   dev_ref  = val[7:0];
            dtc_pkg::REG_DEV_AUX_A: dev_a    = val[7:0];
            dtc_pkg::REG_DEV_AUX_B: dev_b    = val[7:0];
            default: ;
        endcase
    endfunction

    // middle of three as max(min(a,b), min(max(a,b),c))
    function logic [7:0] middle_of(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        logic [7:0] lo_ab;
        logic [7:0] hi_ab;
        logic [7:0] m;
        lo_ab = (a < b) ? a : b;
        hi_ab = (a < b) ? b : a;
        m = (hi_ab < c) ? hi_ab : c;
        return (lo_ab > m) ? lo_ab : m;
    endfunction

    function int sample_offset();
        return int'(dev_ref) - int'(middle_of(dev_ref, dev_a, dev_b));
    endfunction

    // reciprocal of gap * 90, scaled by 2^23
    function logic [11:0] recip(logic [7:0] gap);
        case (gap)
            8'd43:   return 12'd2168;
            8'd44:   return 12'd2118;
            8'd45:   return 12'd2071;
            8'd46:   return 12'd2026;
            8'd47:   return 12'd1983;
            8'd48:   return 12'd1942;
            8'd49:   return 12'd1902;
            8'd50:   return 12'd1864;
            8'd51:   return 12'd1828;
            default: return 12'd0;
        endcase
    endfunction

    function t_reading convert(t_sample it);
        int          corr;
        int          idx;
        logic [7:0]  s;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  gap;
        logic [15:0] vbg;
        logic [31:0] acc;
        t_reading    r;
        r.temp = '0;
        // deviation correction with clamp
        corr = int'(it.sample) - sample_offset();
        if (corr > 255) corr = 255;
        else if (corr < 0) corr = 0;
        s = corr[7:0];
        if (s < it.lvl[0] || s > it.lvl[4] || !it.pass) begin
            r.status = dtc_pkg::STATUS_REJECTED;
            return r;
        end
        // reference pair selection, strict compare from the top
        if (s > it.lvl[3]) idx = 3;
        else if (s > it.lvl[2]) idx = 2;
        else if (s > it.lvl[1]) idx = 1;
        else idx = 0;
        lo  = it.lvl[idx];
        hi  = it.lvl[idx + 1];
        gap = hi - lo;
        if (gap < dtc_pkg::GAP_MIN || gap > dtc_pkg::GAP_MAX) begin
            r.status = dtc_pkg::STATUS_BAD_GAP;
            return r;
        end
        vbg = band_gap;
        if (vbg < dtc_pkg::VBG_MIN || vbg > dtc_pkg::VBG_MAX) vbg = dtc_pkg::VBG_DEFAULT;
        // 32-bit wrapping fixed-point chain
        acc = 32'(gap) * (32'(idx) + 32'(dtc_pkg::ID_BIAS)) + 32'(s) - 32'(hi);
        acc = acc * 32'(recip(gap));
        acc = acc * 32'(vbg);
        acc = acc >> dtc_pkg::RESULT_SHIFT;
        r.temp   = 10'(acc - 32'(dtc_pkg::TEMP_BIAS));
        r.status = dtc_pkg::STATUS_OK;
        return r;
    endfunction

    function void note_sample(t_sample it);
        reading_q.push_back(convert(it));
    endfunction

    function void check_result(logic [9:0] temp, logic [1:0] status);
        t_reading want;
        if (reading_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %0d status %0d",
                     $time, $signed(temp), status);
            return;
        end
        want = reading_q.pop_front();
        if (temp !== want.temp) begin
            errors++;
            $display("%0t: temperature mismatch, expected %0d, actual %0d",
                     $time, $signed(want.temp), $signed(temp));
        end
        if (status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status);
        end
    endfunction

    function int pending();
        return reading_q.size();
    endfunction
endclass

module tb;
    import dtc_pkg::*;

    localparam int PHASES         = 8;
    localparam int RANDOM_PER_PH  = 235;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // indexes outside the register file, writes must be ignored
    localparam logic [7:0] REG_UNUSED_LOW  = 8'd4;
    localparam logic [7:0] REG_UNUSED_HIGH = 8'hFF;

    logic i_clk;
    logic i_rst_n;

    dtc_in_if  in_ch();
    dtc_out_if out_ch();
    dtc_cfg_if cfg_ch();

    diode_temperature_conversion dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    temp_scoreboard sb = new();

    bit tx_idle  = 1'b1;
    bit rx_quiet = 1'b0;
    bit hold_req = 1'b0;
    int stall_cycles = 0;

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // observe every transaction on the three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
            if (in_ch.valid && in_ch.ready)
                sb.note_sample({in_ch.diode_sample, in_ch.pass_seen,
                                in_ch.ref_level_4, in_ch.ref_level_3, in_ch.ref_level_2,
                                in_ch.ref_level_1, in_ch.ref_level_0});
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.temperature, out_ch.status);
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver with random stalls and one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (rx_quiet || $urandom_range(0, 4) != 0) begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
        end
    end

    function automatic t_sample mk(int smp, int ps, int l0, int l1, int l2, int l3, int l4);
        t_sample it;
        it.sample = smp[7:0];
        it.pass   = ps[0];
        it.lvl[0] = l0[7:0];
        it.lvl[1] = l1[7:0];
        it.lvl[2] = l2[7:0];
        it.lvl[3] = l3[7:0];
        it.lvl[4] = l4[7:0];
        return it;
    endfunction

    // mostly rising reference ladders with legal gaps, plus raw noise
    function automatic t_sample gen_sample(int offset);
        t_sample    it;
        int         target;
        int         raw;
        logic [7:0] g;
        if ($urandom_range(0, 9) < 2) begin
            it.sample = 8'($urandom);
            it.pass   = 1'($urandom);
            for (int i = 0; i < 5; i++) it.lvl[i] = 8'($urandom);
            return it;
        end
        it.lvl[0] = 8'($urandom_range(0, 51));
        for (int i = 1; i < 5; i++) begin
            if ($urandom_range(0, 11) == 0) g = 8'($urandom_range(0, 255));
            else g = 8'($urandom_range(43, 51));
            it.lvl[i] = it.lvl[i-1] + g;
        end
        it.pass = ($urandom_range(0, 15) != 0);
        if ($urandom_range(0, 7) == 0)
            target = int'(it.lvl[$urandom_range(0, 4)]) + int'($urandom_range(0, 2)) - 1;
        else if (it.lvl[0] <= it.lvl[4])
            target = $urandom_range(it.lvl[0], it.lvl[4]);
        else
            target = $urandom_range(0, 255);
        raw = target + offset;
        if (raw > 255) raw = 255;
        else if (raw < 0) raw = 0;
        it.sample = raw[7:0];
        return it;
    endfunction

    task automatic send_sample(t_sample it);
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.diode_sample <= it.sample;
        in_ch.pass_seen    <= it.pass;
        in_ch.ref_level_0  <= it.lvl[0];
        in_ch.ref_level_1  <= it.lvl[1];
        in_ch.ref_level_2  <= it.lvl[2];
        in_ch.ref_level_3  <= it.lvl[3];
        in_ch.ref_level_4  <= it.lvl[4];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_cal(logic [7:0] idx, logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // main sequence
    initial begin
        logic [15:0] bg_set [PHASES]  = '{16'd2300, 16'd3000, 16'd2299, 16'd3001,
                                          16'd0, 16'd65535, 16'd2700, 16'd2700};
        logic [7:0]  ref_set [PHASES] = '{8'd30, 8'd0, 8'd255, 8'd100,
                                          8'd200, 8'd0, 8'd0, 8'd7};
        logic [7:0]  a_set [PHASES]   = '{8'd10, 8'd255, 8'd0, 8'd90,
                                          8'd150, 8'd0, 8'd0, 8'd5};
        logic [7:0]  b_set [PHASES]   = '{8'd20, 8'd128, 8'd0, 8'd110,
                                          8'd180, 8'd0, 8'd0, 8'd3};

        in_ch.valid        <= 1'b0;
        in_ch.diode_sample <= '0;
        in_ch.pass_seen    <= 1'b0;
        in_ch.ref_level_0  <= '0;
        in_ch.ref_level_1  <= '0;
        in_ch.ref_level_2  <= '0;
        in_ch.ref_level_3  <= '0;
        in_ch.ref_level_4  <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.data        <= '0;
        i_rst_n            <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed transactions under reset calibration
        send_sample(mk(40, 1, 40, 85, 130, 175, 220));
        send_sample(mk(220, 1, 40, 85, 130, 175, 220));
        send_sample(mk(39, 1, 40, 85, 130, 175, 220));
        send_sample(mk(221, 1, 40, 85, 130, 175, 220));
        send_sample(mk(100, 0, 40, 85, 130, 175, 220));
        send_sample(mk(85, 1, 40, 85, 130, 175, 220));
        send_sample(mk(86, 1, 40, 85, 130, 175, 220));
        send_sample(mk(131, 1, 40, 85, 130, 175, 220));
        send_sample(mk(176, 1, 40, 85, 130, 175, 220));
        send_sample(mk(0, 1, 0, 43, 86, 129, 172));
        send_sample(mk(255, 1, 51, 102, 153, 204, 255));
        send_sample(mk(60, 1, 20, 62, 110, 150, 200));
        send_sample(mk(100, 1, 20, 62, 114, 150, 200));
        send_sample(mk(120, 1, 40, 200, 100, 150, 220));
        send_sample(mk(255, 1, 255, 255, 255, 255, 255));
        send_sample(mk(0, 1, 0, 0, 0, 0, 0));
        send_sample(mk(0, 0, 0, 0, 0, 0, 0));
        send_sample(mk(255, 0, 255, 255, 255, 255, 255));
        send_sample(mk(170, 1, 10, 60, 110, 160, 210));
        send_sample(mk(0, 1, 255, 255, 255, 255, 255));

        for (int p = 0; p < PHASES; p++) begin
            drain();
            // calibration only while the pipeline is empty
            if (p == 5) begin
                write_cal(REG_BAND_GAP, 16'($urandom_range(VBG_MIN, VBG_MAX)));
                write_cal(REG_DEV_REF, 16'($urandom_range(0, 255)));
                write_cal(REG_DEV_AUX_A, 16'($urandom_range(0, 255)));
                write_cal(REG_DEV_AUX_B, 16'($urandom_range(0, 255)));
            end else if (p == 6) begin
                write_cal(REG_BAND_GAP, 16'($urandom));
                write_cal(REG_DEV_REF, 16'($urandom_range(0, 40)));
                write_cal(REG_DEV_AUX_A, 16'($urandom_range(0, 40)));
                write_cal(REG_DEV_AUX_B, 16'($urandom_range(0, 40)));
                write_cal(REG_UNUSED_LOW, 16'($urandom));
                write_cal(REG_UNUSED_HIGH, 16'($urandom));
            end else begin
                write_cal(REG_BAND_GAP, bg_set[p]);
                write_cal(REG_DEV_REF, {8'd0, ref_set[p]});
                write_cal(REG_DEV_AUX_A, {8'd0, a_set[p]});
                write_cal(REG_DEV_AUX_B, {8'd0, b_set[p]});
            end
            tx_idle  = !(p == 3 || p == PHASES - 1);
            rx_quiet = (p == 1 || p == PHASES - 1);
            for (int n = 0; n < RANDOM_PER_PH; n++) begin
                if (p == 4 && n == 40) hold_req = 1'b1;
                send_sample(gen_sample(sb.sample_offset()));
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
